// ----- hw/rtl/two_segment_send_dma_unit_macros.svh -----
// Assertion macros used by the checker file of the send DMA unit.
`ifndef TWO_SEGMENT_SEND_DMA_UNIT_MACROS_SVH
`define TWO_SEGMENT_SEND_DMA_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TSSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tssd_pkg.sv -----
// Package with the types and codes of the two-segment send DMA unit.
`timescale 1ns / 1ps

package tssd_pkg;

	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned SEG_WORDS_W = 16;
	localparam int unsigned COUNT_W     = 17;
	localparam int unsigned LINK_W      = 32;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_COPY   = 2'd2,
		MODE_FINISH = 2'd3
	} tssd_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_ADDR  = 3'd0,
		REG_SECOND_ADDR = 3'd1,
		REG_FIRST_WORDS = 3'd2,
		REG_SECOND_WORDS = 3'd3,
		REG_DIRECTION   = 3'd4
	} tssd_reg_t;

	typedef struct packed {
		logic              start_pulse;
		logic              kernel_busy;
		logic              link_credit;
		logic              read_grant;
		logic [LINK_W-1:0] memory_word;
		logic              clear_engine;
	} tssd_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] read_address;
		logic              word_valid;
		logic [LINK_W-1:0] link_word;
		logic              end_of_packet;
		logic              engine_busy;
	} tssd_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} tssd_cfg_t;

	// Segment setup as held by the configuration registers.
	typedef struct packed {
		logic [ADDR_W-1:0]      first_segment_address;
		logic [ADDR_W-1:0]      second_segment_address;
		logic [SEG_WORDS_W-1:0] first_segment_words;
		logic [SEG_WORDS_W-1:0] second_segment_words;
		logic                   transfer_direction;
	} tssd_seg_cfg_t;

endpackage

// ----- hw/rtl/tssd_if.sv -----
// Valid/ready channel interfaces for input ticks, results and configuration writes.
`timescale 1ns / 1ps

interface tssd_in_if;
	logic              valid;
	logic              ready;
	tssd_pkg::tssd_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tssd_out_if;
	logic               valid;
	logic               ready;
	tssd_pkg::tssd_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tssd_cfg_if;
	logic               valid;
	logic               ready;
	tssd_pkg::tssd_cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tssd_cfg_regs.sv -----
// Configuration register file of the send DMA unit.
`timescale 1ns / 1ps

module tssd_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	tssd_cfg_if.sink                cfg,
	output tssd_pkg::tssd_seg_cfg_t seg_cfg
);
	import tssd_pkg::*;

	tssd_seg_cfg_t regs_q;
	logic          wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;
	assign seg_cfg   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en) begin
			// Drop writes to indexes beyond the register list.
			unique case (cfg.payload.index)
				REG_FIRST_ADDR:   regs_q.first_segment_address  <= cfg.payload.data;
				REG_SECOND_ADDR:  regs_q.second_segment_address <= cfg.payload.data;
				REG_FIRST_WORDS: begin
					regs_q.first_segment_words <= cfg.payload.data[SEG_WORDS_W-1:0];
				end
				REG_SECOND_WORDS: begin
					regs_q.second_segment_words <= cfg.payload.data[SEG_WORDS_W-1:0];
				end
				REG_DIRECTION:    regs_q.transfer_direction <= cfg.payload.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/two_segment_send_dma_unit.sv -----
// Top level of the two-segment send DMA unit with credit flow control.
//
//  channel | role  | payload          | request means
//  --------+-------+------------------+---------------------------------------
//  in_ch   | sink  | tssd_in_t        | one clock tick of link-side inputs
//  out_ch  | source| tssd_out_t       | engine outputs after that tick
//  cfg     | sink  | tssd_cfg_t       | one register write (index, data)
//
// One request is taken per cycle; its result sits in the output register on
// the next cycle. The input side stalls only while that register is full and
// the sink does not take it. Reset clears configuration, engine state and
// the output valid flag, not the output data; the block is ready right after
// reset with no clearing pass. Configuration writes complete when offered.
`timescale 1ns / 1ps

module two_segment_send_dma_unit #(
	parameter int unsigned WORD_BYTES = 4,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tssd_in_if.sink    in_ch,
	tssd_out_if.source out_ch,
	tssd_cfg_if.sink   cfg
);
	import tssd_pkg::*;

	// Bits of a memory word that survive onto the link.
	localparam int unsigned KEPT_W = (DATA_WIDTH < LINK_W) ? DATA_WIDTH : LINK_W;
	localparam logic [ADDR_W-1:0] STEP  = ADDR_W'(WORD_BYTES);
	localparam logic [ADDR_W-1:0] STEP2 = ADDR_W'(2 * WORD_BYTES);

	tssd_seg_cfg_t seg_cfg;

	tssd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.seg_cfg (seg_cfg)
	);

	// Engine state.
	tssd_mode_t             mode_q, mode_d;
	logic [ADDR_W-1:0]      addr_q, addr_d;
	logic [ADDR_W-1:0]      second_addr_q, second_addr_d;
	logic [COUNT_W-1:0]     words_q, words_d;
	logic [SEG_WORDS_W-1:0] second_words_q, second_words_d;
	logic                   valid_q, valid_d;
	logic                   last_q, last_d;
	logic [KEPT_W-1:0]      word_q, word_d;
	logic                   busy_q, busy_d;

	// Output register.
	logic      out_valid_q;
	tssd_out_t out_data_q;

	logic     in_fire;
	tssd_in_t tick;
	logic     can_start;
	logic     link_ok;
	logic     first_done;
	logic     second_pending;

	assign tick    = in_ch.payload;
	// Take a new tick whenever the output register is empty or drains now.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	assign can_start      = tick.start_pulse && !seg_cfg.transfer_direction && !tick.kernel_busy;
	assign link_ok        = tick.link_credit && tick.read_grant;
	assign first_done     = (words_q == '0);
	assign second_pending = (second_words_q != '0);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (tick.clear_engine) begin
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (can_start) mode_d = MODE_LOAD;
				end
				MODE_LOAD: begin
					if (link_ok) mode_d = MODE_COPY;
				end
				MODE_COPY: begin
					if (!link_ok) mode_d = MODE_LOAD;
					else if (!first_done) mode_d = MODE_COPY;
					else if (second_pending) mode_d = MODE_LOAD;
					else mode_d = MODE_FINISH;
				end
				MODE_FINISH: mode_d = MODE_IDLE;
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	// Datapath updates for the tick.
	always_comb begin
		addr_d         = addr_q;
		second_addr_d  = second_addr_q;
		words_d        = words_q;
		second_words_d = second_words_q;
		valid_d        = valid_q;
		last_d         = last_q;
		word_d         = word_q;
		busy_d         = busy_q;
		if (tick.clear_engine) begin
			// Clear drops the flags only; addresses, counts and the word hold.
			valid_d = 1'b0;
			last_d  = 1'b0;
			busy_d  = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (can_start) begin
						addr_d         = seg_cfg.first_segment_address;
						second_addr_d  = seg_cfg.second_segment_address;
						words_d        = COUNT_W'(seg_cfg.first_segment_words);
						second_words_d = seg_cfg.second_segment_words;
						busy_d         = 1'b1;
					end
				end
				MODE_LOAD: begin
					if (link_ok) addr_d = addr_q + STEP;
				end
				MODE_COPY: begin
					if (link_ok) begin
						if (!first_done) begin
							// Send one word and advance.
							valid_d = 1'b1;
							word_d  = tick.memory_word[KEPT_W-1:0];
							addr_d  = addr_q + STEP;
							last_d  = !second_pending && (words_q == COUNT_W'(1));
							words_d = words_q - COUNT_W'(1);
						end else if (second_pending) begin
							// Switch to the second segment; a set bit in 30..28
							// moves its start one word down.
							words_d        = COUNT_W'(second_words_q);
							second_words_d = '0;
							valid_d        = 1'b0;
							if (second_addr_q[30:28] == 3'b000) addr_d = second_addr_q;
							else addr_d = second_addr_q - STEP;
						end else begin
							valid_d = 1'b0;
							last_d  = 1'b0;
						end
					end else begin
						// Rewind: two words without credit (and give the count
						// back), one word without grant.
						last_d  = 1'b0;
						valid_d = 1'b0;
						if (!tick.link_credit) begin
							words_d = words_q + COUNT_W'(1);
							addr_d  = addr_q - STEP2;
						end else begin
							addr_d = addr_q - STEP;
						end
					end
				end
				MODE_FINISH: begin
					busy_d         = 1'b0;
					addr_d         = '0;
					second_addr_d  = '0;
					words_d        = '0;
					second_words_d = '0;
				end
				default: ;
			endcase
		end
	end

	// Advance the engine on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			addr_q         <= '0;
			second_addr_q  <= '0;
			words_q        <= '0;
			second_words_q <= '0;
			valid_q        <= 1'b0;
			last_q         <= 1'b0;
			word_q         <= '0;
			busy_q         <= 1'b0;
		end else if (in_fire) begin
			mode_q         <= mode_d;
			addr_q         <= addr_d;
			second_addr_q  <= second_addr_d;
			words_q        <= words_d;
			second_words_q <= second_words_d;
			valid_q        <= valid_d;
			last_q         <= last_d;
			word_q         <= word_d;
			busy_q         <= busy_d;
		end
	end

	// Hold the result until the sink takes it; load the new one on a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q.read_address  <= addr_d;
			out_data_q.word_valid    <= valid_d;
			out_data_q.link_word     <= LINK_W'(word_d);
			out_data_q.end_of_packet <= last_d;
			out_data_q.engine_busy   <= busy_d;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_data_q;

endmodule

// ----- hw/rtl/tssd_checker.sv -----
// Port-level assertion checker for the send DMA unit, with its bind.
`timescale 1ns / 1ps
`include "two_segment_send_dma_unit_macros.svh"

module tssd_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tssd_pkg::tssd_out_t out_payload
);
	import tssd_pkg::*;

	logic in_fire;
	logic stalled;
	logic eop_out;
	logic word_out;

	assign in_fire  = in_valid && in_ready;
	assign stalled  = out_valid && !out_ready;
	assign eop_out  = out_valid && out_payload.end_of_packet;
	assign word_out = out_valid && out_payload.word_valid;

	// A stalled result holds.
	`TSSD_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(out_payload), "result moved")
	// Every accepted tick leaves a result behind it.
	`TSSD_ASSERT_NEXT(a_tick_result, clk, arst_n, in_fire, out_valid, "accepted tick gave no result")
	// End of packet only rides on a word that is sent.
	`TSSD_ASSERT_SAME(a_eop_word, clk, arst_n, eop_out, out_payload.word_valid, "eop without a word")
	// Words go out only during a transfer.
	`TSSD_ASSERT_SAME(a_word_busy, clk, arst_n, word_out, out_payload.engine_busy, "word while idle")

endmodule

bind two_segment_send_dma_unit tssd_port_checker u_tssd_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
